[hw/rtl/mbrtu_pkg.sv]
// ----------------------------------------------------------------------------
// mbrtu_pkg
// Shared types, constants and the CRC-16 byte fold for the Modbus RTU
// input-register responder.
// ----------------------------------------------------------------------------
package mbrtu_pkg;

  localparam int DefStoreDepth = 8;
  localparam int HdrLen        = 6;
  localparam int CountCap      = 8;

  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [7:0]  FuncRdInput = 8'h04;
  localparam logic [7:0]  ExcFlag     = 8'h80;
  localparam logic [7:0]  ExcIllFunc  = 8'h01;
  localparam logic [7:0]  ExcIllAddr  = 8'h02;
  localparam logic [7:0]  ExcIllValue = 8'h03;
  localparam logic [7:0]  ExcCrc      = 8'h05;
  localparam logic [7:0]  ExcNone     = 8'h00;

  localparam logic [1:0] CfgFirstAddr = 2'd0;
  localparam logic [1:0] CfgLastAddr  = 2'd1;
  localparam logic [1:0] CfgMaxCount  = 2'd2;

  localparam logic [0:0] FuncRxByte  = 1'b0;
  localparam logic [0:0] FuncStoreWr = 1'b1;

  typedef struct packed {
    logic [0:0]  func;
    logic [7:0]  rx_byte;
    logic [0:0]  rx_last;
    logic [7:0]  store_index;
    logic [15:0] store_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic [0:0] tx_last;
  } out_item_t;

  // controller -> datapath commands
  typedef struct packed {
    logic rx_take;     // absorb one request byte
    logic store_wr;    // write sensor value
    logic eval;        // latch check result
    logic tx_start;    // load first response byte
    logic tx_adv;      // step to next response byte
    logic frame_clr;   // return frame state to reset
  } dp_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic tx_done;     // current byte is the last of the frame
  } dp_sts_t;

  function automatic logic [15:0] crc_fold(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[hw/rtl/mbrtu_ctrl.sv]
// ----------------------------------------------------------------------------
// mbrtu_ctrl
// Sequencer: takes input beats, triggers evaluation, walks out the response.
// ----------------------------------------------------------------------------
module mbrtu_ctrl
  import mbrtu_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  in_item_t in_item,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StEval = 2'd1;
  localparam logic [1:0] StLoad = 2'd2;
  localparam logic [1:0] StSend = 2'd3;

  logic [1:0] state, state_next;
  logic       in_acc, out_acc;

  assign in_stall  = (state != StIdle);
  assign out_valid = (state == StSend);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      StIdle: begin
        if (in_acc) begin
          if (in_item.func == FuncStoreWr) begin
            cmd.store_wr = 1'b1;
          end else begin
            cmd.rx_take = 1'b1;
            if (in_item.rx_last == 1'b1) state_next = StEval;
          end
        end
      end
      StEval: begin
        cmd.eval   = 1'b1;
        state_next = StLoad;
      end
      StLoad: begin
        cmd.tx_start = 1'b1;
        state_next   = StSend;
      end
      StSend: begin
        if (out_acc) begin
          if (sts.tx_done) begin
            cmd.frame_clr = 1'b1;
            state_next    = StIdle;
          end else begin
            cmd.tx_adv = 1'b1;
          end
        end
      end
      default: state_next = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= StIdle;
    else     state <= state_next;
  end

endmodule

[hw/rtl/mbrtu_dp.sv]
// ----------------------------------------------------------------------------
// mbrtu_dp
// Datapath: header capture, running CRC, request checks, register store and
// the response byte generator with its own CRC.
// ----------------------------------------------------------------------------
module mbrtu_dp
  import mbrtu_pkg::*;
#(
  parameter int STORE_DEPTH = DefStoreDepth
)(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  in_item_t  in_item,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts,
  output out_item_t out_item
);

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  logic [7:0]  first_reg_addr, last_reg_addr;
  logic [3:0]  max_reg_count;
  logic [7:0]  byte_count;
  logic [7:0]  hdr [HdrLen];
  logic [15:0] running_crc;
  logic [7:0]  dly0, dly1;
  logic [15:0] store [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] wr_flag;   // set once an entry was written

  // response state
  logic [7:0]  exc_code;
  logic [4:0]  tx_len;      // bytes before CRC
  logic [4:0]  tx_pos;
  logic [15:0] tx_crc;
  logic [7:0]  tx_byte;
  logic [7:0]  rd_addr;
  logic [15:0] rd_word;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      first_reg_addr <= 8'd0;
      last_reg_addr  <= 8'd6;
      max_reg_count  <= 4'd7;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgFirstAddr: first_reg_addr <= cfg_data;
        CfgLastAddr:  last_reg_addr  <= cfg_data;
        CfgMaxCount:  max_reg_count  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // store: unwritten entries read as 0x0002
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_flag <= '0;
    end else if (cmd.store_wr && ({24'd0, in_item.store_index} < STORE_DEPTH)) begin
      wr_flag[in_item.store_index[AW-1:0]] <= 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.store_wr && ({24'd0, in_item.store_index} < STORE_DEPTH))
      store[in_item.store_index[AW-1:0]] <= in_item.store_value;
  end

  // request capture
  always_ff @(posedge clk) begin
    if (rst || cmd.frame_clr) begin
      byte_count  <= 8'd0;
      running_crc <= CrcInit;
      dly0        <= 8'd0;
      dly1        <= 8'd0;
      for (int i = 0; i < HdrLen; i++) hdr[i] <= 8'd0;
    end else if (cmd.rx_take) begin
      if (byte_count < HdrLen) hdr[byte_count[2:0]] <= in_item.rx_byte;
      if (byte_count >= 8'd2) running_crc <= crc_fold(running_crc, dly0);
      dly0 <= dly1;
      dly1 <= in_item.rx_byte;
      if (byte_count != 8'hFF) byte_count <= byte_count + 8'd1;
    end
  end

  // checks
  logic [3:0] limit;
  logic [8:0] sum_end;
  logic [7:0] code_c;
  assign limit   = (max_reg_count > 4'd8) ? 4'd8 : max_reg_count;
  assign sum_end = {1'b0, hdr[3]} + {1'b0, hdr[5]};
  always_comb begin
    code_c = ExcNone;
    if (byte_count < 8'd2 || {dly1, dly0} != running_crc) code_c = ExcCrc;
    else if (hdr[1] != FuncRdInput) code_c = ExcIllFunc;
    else if (hdr[4] != 8'd0 || hdr[5] == 8'd0 || hdr[5] > {4'd0, limit})
      code_c = ExcIllValue;
    else if (hdr[2] != 8'd0 || hdr[3] < first_reg_addr || hdr[3] > last_reg_addr ||
             sum_end > ({1'b0, last_reg_addr} + 9'd1))
      code_c = ExcIllAddr;
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      exc_code <= code_c;
      tx_len   <= (code_c != ExcNone) ? 5'd3 : (5'd3 + {hdr[5][3:0], 1'b0});
    end
  end

  // byte generator
  logic [4:0] body_pos;
  logic [7:0] body_byte;
  always_comb begin
    body_pos = tx_pos - 5'd3;
    rd_addr  = hdr[3] + {4'd0, body_pos[4:1]};
    if ({24'd0, rd_addr} < STORE_DEPTH)
      rd_word = wr_flag[rd_addr[AW-1:0]] ? store[rd_addr[AW-1:0]] : 16'h0002;
    else
      rd_word = 16'h0000;
    if (tx_pos == 5'd0)      body_byte = hdr[0];
    else if (tx_pos == 5'd1) body_byte = (exc_code != ExcNone) ? (hdr[1] + ExcFlag) : FuncRdInput;
    else if (tx_pos == 5'd2) body_byte = (exc_code != ExcNone) ? exc_code : {hdr[5][6:0], 1'b0};
    else                     body_byte = body_pos[0] ? rd_word[7:0] : rd_word[15:8];
  end

  always_ff @(posedge clk) begin
    if (cmd.tx_start) begin
      tx_pos <= 5'd0;
      tx_crc <= CrcInit;
    end else if (cmd.tx_adv) begin
      tx_pos <= tx_pos + 5'd1;
      if (tx_pos < tx_len) tx_crc <= crc_fold(tx_crc, tx_byte);
    end
  end

  always_comb begin
    if (tx_pos < tx_len)              tx_byte = body_byte;
    else if (tx_pos == tx_len)        tx_byte = tx_crc[7:0];
    else                              tx_byte = tx_crc[15:8];
  end

  assign sts.tx_done       = (tx_pos == tx_len + 5'd1);
  assign out_item.tx_byte  = tx_byte;
  assign out_item.tx_last  = sts.tx_done;

endmodule

[hw/rtl/modbus_rtu_input_register_slave.sv]
// ----------------------------------------------------------------------------
// modbus_rtu_input_register_slave
// Modbus RTU responder for function 0x04 (read input registers).
// ----------------------------------------------------------------------------
// Usage: the input channel carries one beat per request byte (func = 0, with
// rx_last on the final byte) or one sensor store write (func = 1). The output
// channel carries response bytes, tx_last on the final one.
// A non-final request byte or a store write is taken while idle. After a
// final byte it checks (StEval) and loads the first byte (StLoad), then
// presents one response byte per cycle unless stalled (5 bytes for an
// exception, 5 + 2*count for data); input stalls until the last byte is taken.
// A stalled output byte holds; the byte sequencer simply waits.
// Reset (synchronous, rst high) clears the frame state and restores config
// defaults; every store entry reads 0x0002 until written.
// Config writes (cfg_we, cfg_index, cfg_data) are taken any cycle.
// ----------------------------------------------------------------------------
module modbus_rtu_input_register_slave
  import mbrtu_pkg::*;
#(
  parameter int STORE_DEPTH = DefStoreDepth
)(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  mbrtu_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_item(in_data), .in_stall,
    .out_valid, .out_stall, .cmd, .sts
  );

  mbrtu_dp #(.STORE_DEPTH(STORE_DEPTH)) u_dp (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_item(in_data), .cmd, .sts, .out_item(out_data)
  );

endmodule

[hw/rtl/mbrtu_checker.sv]
// ----------------------------------------------------------------------------
// mbrtu_checker
// Port-level checks on the responder, bound to the top level.
// ----------------------------------------------------------------------------
module mbrtu_checker
  import mbrtu_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // never accepts and emits in the same cycle
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && !in_stall)) else $error("input open while sending");

  // stalled output beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled beat changed");

  // after last beat taken, input reopens
  a_reopen: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && out_data.tx_last |=> !in_stall && !out_valid)
    else $error("no return to idle");

  // a response begins once StEval and StLoad have passed after input closes
  a_start: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |=> !out_valid ##1 out_valid)
    else $error("response start timing");

endmodule

bind modbus_rtu_input_register_slave mbrtu_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);

[tb/sv/tb_modbus_rtu_input_register_slave.sv]
// ----------------------------------------------------------------------------
// tb_modbus_rtu_input_register_slave
// Self-checking bench for the function 0x04 responder: request frames and
// sensor writes go in, response bytes are predicted and compared one by one.
// ----------------------------------------------------------------------------
class mb_scoreboard;
  mbrtu_pkg::out_item_t pending_bytes[$];
  int errors;
  int checked;

  function void note_input(mbrtu_pkg::out_item_t rsp[$]);
    foreach (rsp[i]) pending_bytes.push_back(rsp[i]);
  endfunction

  function void check_output(mbrtu_pkg::out_item_t got);
    mbrtu_pkg::out_item_t want;
    checked++;
    if (pending_bytes.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected byte %02h last=%0d", got.tx_byte, got.tx_last);
      return;
    end
    want = pending_bytes.pop_front();
    if (want.tx_byte !== got.tx_byte || want.tx_last !== got.tx_last) begin
      errors++;
      if (errors <= 10)
        $display("byte mismatch: exp %02h/%0d got %02h/%0d",
                 want.tx_byte, want.tx_last, got.tx_byte, got.tx_last);
    end
  endfunction
endclass

module tb_modbus_rtu_input_register_slave;
  import mbrtu_pkg::*;

  localparam int Depth = 8;
  localparam int WatchLimit = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CfgFirstAddr;
  logic [7:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;

  modbus_rtu_input_register_slave DUT (.*);

  always #4 clk = ~clk;

  mb_scoreboard sb = new();

  // predictor state
  logic [7:0] p_first, p_last;
  logic [3:0] p_maxcnt;
  logic [7:0] p_count;
  logic [7:0] p_hdr[HdrLen];
  logic [15:0] p_crc;
  logic [7:0] p_dly[2];
  logic [15:0] p_store[Depth];
  int frames, exc_frames, stores;
  int idle_cycles = 0;
  int out_wait;
  bit stim_done = 0;

  function automatic logic [15:0] fold_byte(logic [15:0] c, logic [7:0] b);
    c ^= {8'h00, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    return c;
  endfunction

  function automatic void clear_frame();
    p_count = 0;
    foreach (p_hdr[i]) p_hdr[i] = 0;
    p_crc = 16'hFFFF;
    p_dly[0] = 0;
    p_dly[1] = 0;
  endfunction

  function automatic void predict_response(in_item_t it);
    out_item_t rsp[$];
    logic [7:0] body[$];
    logic [7:0] code;
    logic [15:0] c, v;
    int lim, start, cnt, a;
    rsp = {};
    code = ExcNone;
    if (it.func == FuncStoreWr) begin
      if (it.store_index < Depth) p_store[it.store_index] = it.store_value;
      stores++;
      return;
    end
    if (p_count < HdrLen) p_hdr[p_count] = it.rx_byte;
    if (p_count >= 2) p_crc = fold_byte(p_crc, p_dly[0]);
    p_dly[0] = p_dly[1];
    p_dly[1] = it.rx_byte;
    if (p_count < 255) p_count++;
    if (!it.rx_last) return;
    lim = (p_maxcnt > CountCap) ? CountCap : p_maxcnt;
    start = p_hdr[3];
    cnt = p_hdr[5];
    if (p_count < 2 || {p_dly[1], p_dly[0]} != p_crc) code = ExcCrc;
    else if (p_hdr[1] != FuncRdInput) code = ExcIllFunc;
    else if (p_hdr[4] != 0 || cnt < 1 || cnt > lim) code = ExcIllValue;
    else if (p_hdr[2] != 0 || start < p_first || start > p_last ||
             start + cnt > int'(p_last) + 1) code = ExcIllAddr;
    body.push_back(p_hdr[0]);
    if (code != ExcNone) begin
      body.push_back(p_hdr[1] + ExcFlag);
      body.push_back(code);
      exc_frames++;
    end else begin
      body.push_back(FuncRdInput);
      body.push_back(8'(cnt * 2));
      for (int i = 0; i < cnt; i++) begin
        a = start + i;
        v = (a < Depth) ? p_store[a] : 16'h0000;
        body.push_back(v[15:8]);
        body.push_back(v[7:0]);
      end
    end
    c = 16'hFFFF;
    foreach (body[i]) begin
      c = fold_byte(c, body[i]);
      rsp.push_back('{tx_byte: body[i], tx_last: 1'b0});
    end
    rsp.push_back('{tx_byte: c[7:0], tx_last: 1'b0});
    rsp.push_back('{tx_byte: c[15:8], tx_last: 1'b1});
    frames++;
    clear_frame();
    sb.note_input(rsp);
  endfunction

  // valid stays high into the next beat when no gap is drawn
  task automatic send_item(in_item_t it);
    int gap;
    gap = $urandom_range(0, 11) * ($urandom_range(0, 3) != 0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    predict_response(it);
  endtask

  task automatic send_byte(logic [7:0] b, bit last);
    in_item_t it;
    it = '0;
    it.func = FuncRxByte;
    it.rx_byte = b;
    it.rx_last = last;
    it.store_index = 8'($urandom());
    it.store_value = 16'($urandom());
    send_item(it);
  endtask

  task automatic send_store(logic [7:0] idx, logic [15:0] val);
    in_item_t it;
    it = '0;
    it.func = FuncStoreWr;
    it.rx_byte = 8'($urandom());
    it.rx_last = 1'($urandom());
    it.store_index = idx;
    it.store_value = val;
    send_item(it);
  endtask

  // sends bytes, appending a CRC (good or corrupted) unless raw
  task automatic send_frame(logic [7:0] bytes[$], bit add_crc, bit bad_crc);
    logic [15:0] c;
    c = 16'hFFFF;
    foreach (bytes[i]) c = fold_byte(c, bytes[i]);
    if (bad_crc) c ^= 16'(1 << $urandom_range(0, 15));
    if (add_crc) begin
      bytes.push_back(c[7:0]);
      bytes.push_back(c[15:8]);
    end
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  task automatic read_req(logic [7:0] dev, logic [7:0] fn, logic [7:0] ahi,
                          logic [7:0] alo, logic [7:0] chi, logic [7:0] clo);
    send_frame('{dev, fn, ahi, alo, chi, clo}, 1, 0);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending_bytes.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CfgFirstAddr: p_first = val;
      CfgLastAddr: p_last = val;
      default: p_maxcnt = val[3:0];
    endcase
    @(posedge clk);
  endtask

  task automatic random_phase(int n);
    logic [7:0] bytes[$];
    int kind, lim, st, cnt, len;
    for (int k = 0; k < n; k++) begin
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        send_store(8'($urandom_range(0, 11) < 10 ? $urandom_range(0, 7) : $urandom()),
                   16'($urandom()));
      end else if (kind < 65) begin
        lim = (p_maxcnt > CountCap) ? CountCap : (p_maxcnt == 0 ? 1 : p_maxcnt);
        cnt = $urandom_range(1, lim);
        st = $urandom_range(p_first, p_last > p_first ? p_last : p_first);
        read_req(8'($urandom()), FuncRdInput, 0, 8'(st), 0, 8'(cnt));
      end else if (kind < 85) begin
        // well-formed CRC, random header fields
        read_req(8'($urandom()), $urandom_range(0, 1) ? FuncRdInput : 8'($urandom()),
                 8'($urandom_range(0, 3) == 0), 8'($urandom_range(0, 12)),
                 8'($urandom_range(0, 3) == 0), 8'($urandom_range(0, 10)));
      end else begin
        len = $urandom_range(1, 9);
        bytes = {};
        repeat (len) bytes.push_back(8'($urandom()));
        send_frame(bytes, $urandom_range(0, 1), $urandom_range(0, 1));
      end
    end
  endtask

  // output side: each beat is held off for a drawn number of stalled cycles
  always @(posedge clk) begin
    if (rst) begin
      out_wait = 0;
      out_stall <= 1'b0;
    end else if (out_valid && !out_stall) begin
      sb.check_output(out_data);
      out_wait = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 11) : 0;
      out_stall <= (out_wait != 0);
    end else if (out_wait != 0) begin
      out_wait--;
      out_stall <= (out_wait != 0);
    end
  end

  // watchdog on accepted beats
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit && !stim_done) begin
      $display("watchdog expired");
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    p_first = 0;
    p_last = 6;
    p_maxcnt = 7;
    foreach (p_store[i]) p_store[i] = 16'h0002;
    clear_frame();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: defaults, unwritten store reads 0x0002
    read_req(8'h01, FuncRdInput, 0, 0, 0, 7);
    send_store(8'h00, 16'hFFFF);
    send_store(8'h07, 16'h0000);
    send_store(8'hFF, 16'h1234);
    send_store(8'h03, 16'hA55A);
    read_req(8'hFF, FuncRdInput, 0, 3, 0, 1);
    read_req(8'h00, 8'h03, 0, 0, 0, 1);
    read_req(8'h11, 8'hFF, 0, 0, 0, 1);
    read_req(8'h11, FuncRdInput, 0, 0, 0, 0);
    read_req(8'h11, FuncRdInput, 0, 0, 0, 8);
    read_req(8'h11, FuncRdInput, 0, 0, 1, 1);
    read_req(8'h11, FuncRdInput, 1, 0, 0, 1);
    read_req(8'h11, FuncRdInput, 0, 6, 0, 2);
    read_req(8'h11, FuncRdInput, 0, 7, 0, 1);
    send_frame('{8'h42}, 0, 0);
    send_frame('{8'h42, 8'h04}, 1, 0);
    send_frame('{8'h42, 8'h04, 8'h00}, 1, 1);
    send_frame('{8'h42, 8'h04, 8'h00, 8'h01, 8'h00, 8'h01, 8'h99}, 1, 0);
    wait_idle();

    // extremes: full range including beyond store, count cap above eight
    write_cfg(CfgFirstAddr, 8'd0);
    write_cfg(CfgLastAddr, 8'd255);
    write_cfg(CfgMaxCount, 8'd15);
    read_req(8'h05, FuncRdInput, 0, 4, 0, 8);
    read_req(8'h05, FuncRdInput, 0, 248, 0, 8);
    read_req(8'h05, FuncRdInput, 0, 250, 0, 8);
    read_req(8'h05, FuncRdInput, 0, 0, 0, 9);
    random_phase(5);
    wait_idle();

    write_cfg(CfgFirstAddr, 8'd2);
    write_cfg(CfgLastAddr, 8'd5);
    write_cfg(CfgMaxCount, 8'd1);
    read_req(8'h07, FuncRdInput, 0, 1, 0, 1);
    random_phase(5);
    wait_idle();

    write_cfg(CfgFirstAddr, 8'd255);
    write_cfg(CfgLastAddr, 8'd255);
    write_cfg(CfgMaxCount, 8'd8);
    random_phase(3);
    wait_idle();

    write_cfg(CfgFirstAddr, 8'd0);
    write_cfg(CfgLastAddr, 8'd7);
    write_cfg(CfgMaxCount, 8'd8);
    random_phase(6);
    wait_idle();
    stim_done = 1;
    repeat (20) @(posedge clk);

    if (sb.pending_bytes.size() != 0) begin
      sb.errors++;
      $display("%0d response bytes never arrived", sb.pending_bytes.size());
    end
    $display("covered %0d response frames (%0d exceptions), %0d store writes, %0d bytes",
             frames, exc_frames, stores, sb.checked);
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

[sim.f]
hw/rtl/mbrtu_pkg.sv
hw/rtl/mbrtu_ctrl.sv
hw/rtl/mbrtu_dp.sv
hw/rtl/modbus_rtu_input_register_slave.sv
hw/rtl/mbrtu_checker.sv
tb/sv/tb_modbus_rtu_input_register_slave.sv
